// File: rtl/efr_pkg.sv
// Shared types and constants of the escaped frame receiver.
package efr_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned IdxW  = 6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_STOP   = 2'd1;
  localparam logic [1:0] CFG_ESCAPE = 2'd2;

  // Register values after reset ('q', 'y', 's').
  localparam logic [CodeW-1:0] START_RST  = 8'd113;
  localparam logic [CodeW-1:0] STOP_RST   = 8'd121;
  localparam logic [CodeW-1:0] ESCAPE_RST = 8'd115;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_NO_START = 2'd1,
    ST_NO_STOP  = 2'd2,
    ST_DELIM    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_WAIT,
    S_DATA,
    S_STOP,
    S_READ,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    store;
    logic    set_esc;
    logic    clr_esc;
    logic    clr_pos;
    logic    load_err;
    status_e err_code;
    logic    rd;
    logic    load_data;
    logic    k_clr;
    logic    k_inc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic is_stop;
    logic is_esc;
    logic esc_pend;
    logic pos_last;
    logic k_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/escaped_frame_receiver.sv
// Top level of the escaped frame receiver: byte-stuffed frame deframer.
//
// The receiver takes one link byte per item on the rx channel and recovers
// frames of FRAME_BYTES data bytes that open with the start code and close
// with the stop code; a byte after the escape code is stored literally. While
// a frame is being collected, one byte is accepted every cycle that the result
// register is free. After a good stop code the block stops accepting bytes and
// plays the frame back from its frame store: each result is first read from
// the store, whose read data is registered, and then loaded into the result
// register once that register is free, and the final data result carries
// last. A stray byte while waiting, a wrong byte where the stop code belongs,
// or an unescaped delimiter among the data produces one error result (last
// set, data zero) and the block goes back to waiting for a start code. The
// three codes are written through the cfg port at index 0 (start), 1 (stop)
// and 2 (escape); index 3 is ignored, and writes are meant to happen while
// the block is idle.
module escaped_frame_receiver
  import efr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration writes.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CodeW-1:0] cfg_data_i,
  // Received link bytes.
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  input  logic [CodeW-1:0] rx_byte_i,
  // Results.
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [CodeW-1:0] data_byte_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic             last_o
);

  cmd_t  cmd;
  stat_t stat;

  // Configuration registers are plain flops, so a write is always taken.
  assign cfg_ready_o = 1'b1;

  // The controller owns the framing decisions and the rx handshake.
  efr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds codes, position, escape flag, frame store and results.
  efr_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .last_o       (last_o)
  );

endmodule

// File: rtl/efr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module efr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/efr_ctrl.sv
// Framing state machine of the escaped frame receiver.
module efr_ctrl
  import efr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  rx_valid_i,
  output logic  rx_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   rx_ready;
  logic   accept;

  assign rx_ready = ((state_q == S_WAIT) || (state_q == S_DATA) || (state_q == S_STOP))
                    && stat_i.out_free;
  assign accept   = rx_valid_i && rx_ready;
  assign rx_ready_o = rx_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_WAIT: begin
        if (accept && stat_i.is_start) state_d = S_DATA;
      end
      S_DATA: begin
        if (accept) begin
          if (stat_i.esc_pend) begin
            if (stat_i.pos_last) state_d = S_STOP;
          end else if (stat_i.is_esc) begin
            state_d = S_DATA;
          end else if (stat_i.is_stop || stat_i.is_start) begin
            state_d = S_WAIT;
          end else if (stat_i.pos_last) begin
            state_d = S_STOP;
          end
        end
      end
      S_STOP: begin
        if (accept) state_d = stat_i.is_stop ? S_READ : S_WAIT;
      end
      S_READ: state_d = S_EMIT;
      S_EMIT: begin
        if (stat_i.out_free) state_d = stat_i.k_last ? S_WAIT : S_READ;
      end
      default: state_d = S_WAIT;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o          = '0;
    cmd_o.err_code = ST_DATA;
    case (state_q)
      S_WAIT: begin
        if (accept) begin
          cmd_o.clr_esc = 1'b1;
          if (stat_i.is_start) begin
            cmd_o.clr_pos = 1'b1;
          end else begin
            cmd_o.load_err = 1'b1;
            cmd_o.err_code = ST_NO_START;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          if (stat_i.esc_pend) begin
            cmd_o.store   = 1'b1;
            cmd_o.clr_esc = 1'b1;
          end else if (stat_i.is_esc) begin
            cmd_o.set_esc = 1'b1;
          end else if (stat_i.is_stop || stat_i.is_start) begin
            cmd_o.load_err = 1'b1;
            cmd_o.err_code = ST_DELIM;
            cmd_o.clr_esc  = 1'b1;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      S_STOP: begin
        if (accept) begin
          cmd_o.clr_esc = 1'b1;
          if (stat_i.is_stop) begin
            cmd_o.k_clr = 1'b1;
          end else begin
            cmd_o.load_err = 1'b1;
            cmd_o.err_code = ST_NO_STOP;
          end
        end
      end
      S_READ: cmd_o.rd = 1'b1;
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_data = 1'b1;
          cmd_o.k_inc     = !stat_i.k_last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/efr_dp.sv
// Datapath of the escaped frame receiver: codes, counters, frame store and result register.
module efr_dp
  import efr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CodeW-1:0] cfg_data_i,
  input  logic [CodeW-1:0] rx_byte_i,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [CodeW-1:0] data_byte_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic             last_o
);

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned PW = $clog2(FRAME_BYTES + 1);

  logic [CodeW-1:0] start_q, stop_q, esc_code_q;
  logic [PW-1:0]    pos_q;
  logic             esc_q;
  logic [AW-1:0]    k_q;
  logic             out_valid_q;
  status_e          status_q;
  logic [CodeW-1:0] data_q;
  logic [IdxW-1:0]  index_q;
  logic             last_q;
  logic [CodeW-1:0] rdata;
  logic             out_free;
  logic             k_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= START_RST;
      stop_q     <= STOP_RST;
      esc_code_q <= ESCAPE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START:  start_q    <= cfg_data_i;
        CFG_STOP:   stop_q     <= cfg_data_i;
        CFG_ESCAPE: esc_code_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  efr_ram #(
    .WIDTH (CodeW),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd),
    .raddr_i (k_q),
    .rdata_o (rdata)
  );

  assign k_last   = (k_q == AW'(FRAME_BYTES - 1));
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      esc_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_pos) begin
        pos_q <= '0;
      end else if (cmd_i.store) begin
        pos_q <= pos_q + PW'(1);
      end
      if (cmd_i.clr_esc) begin
        esc_q <= 1'b0;
      end else if (cmd_i.set_esc) begin
        esc_q <= 1'b1;
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + AW'(1);
      end
      if (cmd_i.load_err || cmd_i.load_data) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; an error carries a zero byte and always closes its item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      status_q <= cmd_i.err_code;
      data_q   <= '0;
      index_q  <= (cmd_i.err_code == ST_NO_START) ? '0 : IdxW'(pos_q);
      last_q   <= 1'b1;
    end else if (cmd_i.load_data) begin
      status_q <= ST_DATA;
      data_q   <= rdata;
      index_q  <= IdxW'(k_q);
      last_q   <= k_last;
    end
  end

  assign stat_o.is_start = (rx_byte_i == start_q);
  assign stat_o.is_stop  = (rx_byte_i == stop_q);
  assign stat_o.is_esc   = (rx_byte_i == esc_code_q);
  assign stat_o.esc_pend = esc_q;
  assign stat_o.pos_last = (pos_q == PW'(FRAME_BYTES - 1));
  assign stat_o.k_last   = k_last;
  assign stat_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_byte_o  = data_q;
  assign byte_index_o = index_q;
  assign last_o       = last_q;

`ifndef NO_ASSERTIONS
  // A new result is only loaded when the result register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_err || cmd_i.load_data) |-> out_free)
    else $error("result register overwritten");

  // The frame store is never written past the end of the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (pos_q < PW'(FRAME_BYTES)))
    else $error("frame store overflow");

  // Error results are single items with a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DATA)) |-> (last_o && (data_byte_o == '0)))
    else $error("malformed error result");

  // The final data byte of a frame carries the last mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_data && k_last) |=> (out_valid_o && last_o))
    else $error("frame end not marked");
`endif

endmodule
